FILE: rtl/pmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types, bit positions and helpers for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int DEFAULT_SCALE_NUM = 1;
  localparam int DEFAULT_SCALE_DEN = 2;

  localparam int HDR_SYNC_BIT = 3;
  localparam int X_SIGN_BIT   = 4;
  localparam int Y_SIGN_BIT   = 5;
  localparam int X_OVF_BIT    = 6;
  localparam int Y_OVF_BIT    = 7;

  localparam int BUTTON_W = 3;
  localparam int DELTA_W  = 9;

  localparam logic [7:0] DELTA_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } pkt_t;

  // Sign-extends a movement byte using its header sign bit, or forces the
  // full-scale value when the overflow bit is set.
  function automatic logic signed [DELTA_W-1:0] axis_delta(
    input logic [7:0] raw,
    input logic       neg,
    input logic       ovf
  );
    logic signed [DELTA_W-1:0] d;
    d = $signed({neg, raw});
    if (ovf) begin
      d = neg ? -$signed({1'b0, DELTA_MAX}) : $signed({1'b0, DELTA_MAX});
    end
    return d;
  endfunction

endpackage

FILE: rtl/pmd_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_assembler
// Filters auxiliary-port bytes and gathers them into three-byte packets,
// resynchronizing on the header's always-one bit.
// ----------------------------------------------------------------------------
module pmd_assembler
  import pmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       enable,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  output pkt_t       pkt,
  output logic       pkt_valid,
  input  logic       pkt_ready
);

  typedef enum logic [2:0] {
    POS_HEADER = 3'b001,
    POS_X      = 3'b010,
    POS_Y      = 3'b100
  } pos_t;

  pos_t       pos;
  pos_t       pos_next;
  logic [7:0] header_byte;
  logic [7:0] x_byte;
  logic       use_byte;
  logic       pkt_done;

  assign s_tready = !pkt_valid || pkt_ready;
  assign use_byte = s_tvalid && s_tready && enable && s_tuser;

  always_comb begin
    pos_next = pos;
    pkt_done = 1'b0;
    unique case (pos)
      POS_HEADER: begin
        if (use_byte && s_tdata[HDR_SYNC_BIT]) begin
          pos_next = POS_X;
        end
      end
      POS_X: begin
        if (use_byte) begin
          pos_next = POS_Y;
        end
      end
      POS_Y: begin
        if (use_byte) begin
          pos_next = POS_HEADER;
          pkt_done = 1'b1;
        end
      end
      default: pos_next = POS_HEADER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HEADER;
      pkt_valid   <= 1'b0;
      header_byte <= '0;
      x_byte      <= '0;
    end else begin
      pos       <= pos_next;
      pkt_valid <= pkt_done || (pkt_valid && !pkt_ready);
      if (use_byte && pos == POS_HEADER && s_tdata[HDR_SYNC_BIT]) begin
        header_byte <= s_tdata;
      end
      if (use_byte && pos == POS_X) begin
        x_byte <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done) begin
      pkt <= '{header_byte: header_byte, x_byte: x_byte, y_byte: s_tdata};
    end
  end

`ifndef SYNTH
  a_pkt_after_y : assert property (@(posedge clk) disable iff (rst)
    $rose(pkt_valid) |-> $past(pos == POS_Y))
    else $error("packet completed outside the last byte position");

  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && !pkt_ready) |=> pkt_valid)
    else $error("pending packet lost while the scaler was busy");

  a_pos_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot(pos))
    else $error("byte position is not one-hot");
`endif

endmodule

FILE: rtl/pmd_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_scaler
// Decodes both deltas of a packet and scales them by SCALE_NUM/SCALE_DEN
// with truncation toward zero, carrying the signed remainders forward.
// ----------------------------------------------------------------------------
module pmd_scaler
  import pmd_pkg::*;
#(
  parameter int SCALE_NUM = DEFAULT_SCALE_NUM,
  parameter int SCALE_DEN = DEFAULT_SCALE_DEN
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pkt_t                      pkt,
  input  logic                      pkt_valid,
  output logic                      pkt_ready,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic signed [DELTA_W-1:0] delta_x,
  output logic signed [DELTA_W-1:0] delta_y,
  output logic [BUTTON_W-1:0]       buttons
);

  localparam int DEN_L   = $clog2(SCALE_DEN);
  localparam int REM_W   = DEN_L + 1;
  localparam int ACC_W   = DELTA_W + 2 + $clog2(SCALE_NUM);
  localparam int MAG_W   = ACC_W - 1;
  localparam int SHIFT   = MAG_W + DEN_L;
  localparam int RECIP_W = MAG_W + 1;
  localparam int PROD_W  = MAG_W + RECIP_W;
  localparam longint RECIP = ((64'd1 << SHIFT) + SCALE_DEN - 1) / SCALE_DEN;

  localparam logic signed [ACC_W-1:0] NUM_S   = ACC_W'(SCALE_NUM);
  localparam logic [PROD_W-1:0]       RECIP_U = PROD_W'(RECIP);
  localparam logic [MAG_W-1:0]        DEN_U   = MAG_W'(SCALE_DEN);

  logic                      m_valid;
  logic                      q_valid;
  logic                      m_move;
  logic                      q_move;
  logic                      p_move;

  logic signed [ACC_W-1:0]   acc_next [2];
  logic signed [ACC_W-1:0]   acc      [2];
  logic [MAG_W-1:0]          mag_next [2];
  logic [PROD_W-1:0]         prod     [2];
  logic [MAG_W-1:0]          mag      [2];
  logic [MAG_W-1:0]          quo      [2];
  logic                      neg      [2];
  logic [MAG_W-1:0]          rmag     [2];
  logic signed [REM_W-1:0]   rem      [2];
  logic signed [REM_W-1:0]   rem_next [2];
  logic [7:0]                qsat     [2];
  logic signed [DELTA_W-1:0] val      [2];
  logic [BUTTON_W-1:0]       m_buttons;
  logic [BUTTON_W-1:0]       q_buttons;

  assign pkt_ready = !m_valid && !q_valid;
  assign p_move    = pkt_valid && pkt_ready;
  assign q_move    = q_valid && (!m_tvalid || m_tready);
  assign m_move    = m_valid && (!q_valid || q_move);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      acc_next[i] = ACC_W'(axis_delta(
                      (i == 0) ? pkt.x_byte : pkt.y_byte,
                      pkt.header_byte[X_SIGN_BIT + i],
                      pkt.header_byte[X_OVF_BIT + i])) * NUM_S
                    + ACC_W'(rem[i]);
      mag_next[i] = acc[i][ACC_W-1] ? MAG_W'(-acc[i]) : MAG_W'(acc[i]);
      prod[i]     = PROD_W'(mag_next[i]) * RECIP_U;
      rmag[i]     = mag[i] - MAG_W'(quo[i] * DEN_U);
      rem_next[i] = neg[i] ? -$signed(REM_W'(rmag[i])) : $signed(REM_W'(rmag[i]));
      qsat[i]     = (quo[i] > MAG_W'(DELTA_MAX)) ? DELTA_MAX : quo[i][7:0];
      val[i]      = neg[i] ? -$signed({1'b0, qsat[i]}) : $signed({1'b0, qsat[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      q_valid  <= 1'b0;
      m_tvalid <= 1'b0;
      rem[0]   <= '0;
      rem[1]   <= '0;
    end else begin
      m_valid  <= p_move || (m_valid && !m_move);
      q_valid  <= m_move || (q_valid && !q_move);
      m_tvalid <= q_move || (m_tvalid && !m_tready);
      if (q_move) begin
        rem[0] <= rem_next[0];
        rem[1] <= rem_next[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      acc[0]    <= acc_next[0];
      acc[1]    <= acc_next[1];
      m_buttons <= pkt.header_byte[BUTTON_W-1:0];
    end
    if (m_move) begin
      for (int i = 0; i < 2; i++) begin
        mag[i] <= mag_next[i];
        quo[i] <= MAG_W'(prod[i] >> SHIFT);
        neg[i] <= acc[i][ACC_W-1];
      end
      q_buttons <= m_buttons;
    end
    if (q_move) begin
      delta_x <= val[0];
      delta_y <= -val[1];
      buttons <= q_buttons;
    end
  end

`ifndef SYNTH
  a_rem_x_bound : assert property (@(posedge clk) disable iff (rst)
    (rem[0] > -SCALE_DEN) && (rem[0] < SCALE_DEN))
    else $error("horizontal remainder out of range");

  a_rem_y_bound : assert property (@(posedge clk) disable iff (rst)
    (rem[1] > -SCALE_DEN) && (rem[1] < SCALE_DEN))
    else $error("vertical remainder out of range");

  a_delta_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (delta_x != -256) && (delta_y != -256))
    else $error("delta beyond full scale");

  a_single_packet : assert property (@(posedge clk) disable iff (rst)
    !(m_valid && q_valid))
    else $error("two packets in flight before the remainder update");
`endif

endmodule

FILE: rtl/ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Three-byte PS/2 mouse packet decoder with fractional delta scaling.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle unless a completed packet waits for the scale
// pipeline; a packet's result passes its stages: sum, reciprocal product, remainder.
// A new packet enters the scale pipeline once the previous one has updated
// the remainders, which holds at full byte rate while the output is not stalled.
// Synchronous reset clears enable, the packet position and the remainders.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder
  import pmd_pkg::*;
#(
  parameter int SCALE_NUM = DEFAULT_SCALE_NUM,
  parameter int SCALE_DEN = DEFAULT_SCALE_DEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,   // enable
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tuser,    // [0] from_aux
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata     // [8:0] delta_x, [17:9] delta_y, [20:18] buttons
);

  logic                      enable;
  pkt_t                      pkt;
  logic                      pkt_valid;
  logic                      pkt_ready;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic [BUTTON_W-1:0]       buttons;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  pmd_assembler u_assembler (
    .clk       (clk),
    .rst       (rst),
    .enable    (enable),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready)
  );

  pmd_scaler #(
    .SCALE_NUM (SCALE_NUM),
    .SCALE_DEN (SCALE_DEN)
  ) u_scaler (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .delta_x   (delta_x),
    .delta_y   (delta_y),
    .buttons   (buttons)
  );

  assign m_tdata = {3'b000, buttons, delta_y, delta_x};

endmodule

FILE: dv/tb_ps2_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_decoder
// Self-checking testbench for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
// Controller bytes go in as beats on the slave stream. A model inside the
// bench tracks the packet assembly, the header sign and overflow handling and
// the scaler with its carried remainders, and queues one motion report per
// completed packet. Reports on the master stream are checked field by field
// against the oldest queued one. Directed tests cover the enable flag, sign
// and overflow extremes, the buttons, resync on a bad header and keyboard
// bytes. A long random stream follows, with random gaps and stalls on both
// streams.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_decoder;
  import pmd_pkg::*;

  localparam int SCALE_NUM    = DEFAULT_SCALE_NUM;
  localparam int SCALE_DEN    = DEFAULT_SCALE_DEN;
  localparam int MOVE_LIMIT   = 255;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 500;

  typedef struct packed {
    logic [BUTTON_W-1:0] buttons;
    logic [DELTA_W-1:0]  delta_y;
    logic [DELTA_W-1:0]  delta_x;
  } motion_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] data_byte
  logic        s_tuser;    // [0] from_aux
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // [8:0] delta_x, [17:9] delta_y, [20:18] buttons

  logic       mouse_en = 1'b0;
  logic [1:0] pkt_pos = 2'd0;
  logic [7:0] hdr_byte = 8'd0;
  logic [7:0] x_raw = 8'd0;
  int         x_rem = 0;
  int         y_rem = 0;
  motion_t    pending_reports[$];
  int         mismatch_count = 0;
  int         accepted_bytes = 0;
  int         cycle_count = 0;
  bit         no_idle = 1'b0;

  ps2_mouse_packet_decoder #(
    .SCALE_NUM(SCALE_NUM),
    .SCALE_DEN(SCALE_DEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int move_value(input logic [7:0] raw, input logic neg,
                                    input logic ovf);
    int v;
    v = int'(raw);
    if (neg) begin
      v -= 256;
    end
    if (ovf) begin
      v = neg ? -MOVE_LIMIT : MOVE_LIMIT;
    end
    return v;
  endfunction

  function automatic int clamp_move(input int v);
    if (v > MOVE_LIMIT) begin
      return MOVE_LIMIT;
    end
    if (v < -MOVE_LIMIT) begin
      return -MOVE_LIMIT;
    end
    return v;
  endfunction

  function automatic void track_byte(input logic [7:0] b, input logic aux);
    int dx;
    int dy;
    int acc;
    motion_t rpt;
    if (!mouse_en || !aux) begin
      return;
    end
    if (pkt_pos == 2'd0) begin
      if (b[HDR_SYNC_BIT]) begin
        hdr_byte = b;
        pkt_pos = 2'd1;
      end
    end else if (pkt_pos == 2'd1) begin
      x_raw = b;
      pkt_pos = 2'd2;
    end else begin
      pkt_pos = 2'd0;
      dx = move_value(x_raw, hdr_byte[X_SIGN_BIT], hdr_byte[X_OVF_BIT]);
      dy = move_value(b, hdr_byte[Y_SIGN_BIT], hdr_byte[Y_OVF_BIT]);
      acc = dx * SCALE_NUM + x_rem;
      dx = clamp_move(acc / SCALE_DEN);
      x_rem = acc % SCALE_DEN;
      acc = dy * SCALE_NUM + y_rem;
      dy = -clamp_move(acc / SCALE_DEN);
      y_rem = acc % SCALE_DEN;
      rpt.delta_x = dx[DELTA_W-1:0];
      rpt.delta_y = dy[DELTA_W-1:0];
      rpt.buttons = hdr_byte[BUTTON_W-1:0];
      pending_reports.push_back(rpt);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic aux);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= aux;
    do @(posedge clk); while (!s_tready);
    if (mouse_en && aux) begin
      accepted_bytes++;
    end
    track_byte(b, aux);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic en);
    cfg_valid <= 1'b1;
    cfg_data  <= en;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mouse_en = en;
  endtask

  task automatic test_disabled_after_reset();
    send_byte(8'h08, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h01, 1'b1);
    wait_idle();
    write_enable(1'b1);
  endtask

  task automatic test_sign_and_overflow();
    send_byte(8'h08, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h3F, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hC8, 1'b1);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b1);
    send_byte(8'hF8, 1'b1);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b1);
  endtask

  task automatic test_header_resync();
    send_byte(8'h07, 1'b1);
    send_byte(8'h09, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h80, 1'b1);
  endtask

  task automatic test_enable_mid_packet();
    send_byte(8'h0B, 1'b1);
    send_byte(8'h40, 1'b1);
    wait_idle();
    write_enable(1'b0);
    send_byte(8'h11, 1'b1);
    wait_idle();
    write_enable(1'b1);
    send_byte(8'h22, 1'b1);
  endtask

  task automatic test_random_stream();
    int start_count;
    int pkt_count;
    int r;
    logic [7:0] hdr;
    start_count = accepted_bytes;
    pkt_count = 0;
    while (accepted_bytes - start_count < RANDOM_BYTES) begin
      pkt_count++;
      no_idle = (pkt_count % 60) >= 45;
      if (pkt_count % 50 == 0) begin
        wait_idle();
        write_enable(1'b0);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom));
        wait_idle();
        write_enable(1'b1);
      end
      hdr = 8'($urandom);
      hdr[HDR_SYNC_BIT] = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_byte(hdr, 1'b1);
        if ($urandom_range(0, 9) == 0) begin
          send_byte(8'($urandom), 1'b0);
        end
        send_byte(8'($urandom), 1'b1);
        send_byte(8'($urandom), 1'b1);
      end else if (r < 80) begin
        send_byte(8'($urandom), 1'b0);
      end else if (r < 92) begin
        send_byte(8'($urandom), 1'b1);
      end else begin
        send_byte(hdr, 1'b1);
        send_byte(8'($urandom), 1'b1);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin : report_check
    int hold;
    int r;
    motion_t got;
    motion_t want;
    hold = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata[20:0];
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: report with none expected, actual %h", $time, m_tdata);
        end else begin
          want = pending_reports.pop_front();
          if (got.delta_x !== want.delta_x) begin
            mismatch_count++;
            $display("%0t: delta_x expected %0d actual %0d", $time,
                     $signed(want.delta_x), $signed(got.delta_x));
          end
          if (got.delta_y !== want.delta_y) begin
            mismatch_count++;
            $display("%0t: delta_y expected %0d actual %0d", $time,
                     $signed(want.delta_y), $signed(got.delta_y));
          end
          if (got.buttons !== want.buttons) begin
            mismatch_count++;
            $display("%0t: buttons expected %0d actual %0d", $time,
                     want.buttons, got.buttons);
          end
        end
      end
      if (no_idle) begin
        m_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          m_tready <= 1'b1;
          hold = $urandom_range(1, 12);
        end else if (r < 92) begin
          m_tready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          m_tready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ps2_mouse_packet_decoder: mismatch");
    $finish;
  end

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'd0;
    s_tuser   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_after_reset();
    test_sign_and_overflow();
    test_header_resync();
    test_enable_mid_packet();
    test_random_stream();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("ps2_mouse_packet_decoder: match");
    end else begin
      $display("ps2_mouse_packet_decoder: mismatch");
    end
    $finish;
  end

endmodule
